// File: hw/rtl/saob_pkg.sv
// Shared types and constants for the straight-alpha over blend pipeline.
// No dependencies; used by the top level and its port checker.
package saob_pkg;

    localparam int ChanW     = 8;
    localparam int ProdW     = 2 * ChanW;
    localparam int NumW      = 3 * ChanW;
    localparam int LaneCount = 4;
    localparam int DivSteps  = ChanW;
    // one product stage, one sum stage, then one quotient bit per stage
    localparam int PipeDepth = 2 + DivSteps;

    localparam int InDataW  = 8 * ChanW;
    localparam int OutDataW = LaneCount * ChanW;

    localparam int LaneRed   = 0;
    localparam int LaneGreen = 1;
    localparam int LaneBlue  = 2;
    localparam int LaneAlpha = 3;

    typedef logic [ChanW-1:0] chan_t;
    typedef logic [ProdW-1:0] prod_t;
    typedef logic [NumW-1:0]  num_t;

    // products after the first multiply stage
    typedef struct packed {
        prod_t                  src_weight;   // src_alpha * 255
        prod_t                  dst_weight;   // dst_alpha * (255 - src_alpha)
        prod_t [LaneBlue:0]     src_prod;     // src colour * src_alpha
        chan_t [LaneBlue:0]     dst_color;
    } prod_stage_t;

    // state of one lane set inside the restoring divider
    typedef struct packed {
        logic                       zero;     // both alphas zero
        prod_t                      divisor;  // weighted alpha sum
        num_t  [LaneCount-1:0]      rem;
        chan_t [LaneCount-1:0]      quo;
    } div_stage_t;

endpackage

// File: hw/rtl/straight_alpha_over_blend.sv
// Straight-alpha Porter-Duff over on RGBA8, exact integer form, fully pipelined.
// Depends on saob_pkg for widths, lane indices and stage record types.
//
//  channel   | direction | handshake        | payload
//  ----------+-----------+------------------+-----------------------------------
//  s_ (in)   | slave     | tvalid / tready  | 64-bit dst RGBA then src RGBA
//  m_ (out)  | master    | tvalid / tready  | 32-bit blended RGBA
//
// One pixel enters per clock unless the output stalls; the stages are one multiply
// stage, one stage that forms the weighted alpha sum, the colour numerators and the
// alpha (sum / 255 by add-and-shift), then eight restoring-divider stages, one
// quotient bit each, for the three colour lanes at once.
// Each stage holds its own valid bit and advances when it is empty or the next
// stage advances, so bubbles close up during a stall and nothing is dropped.
// Synchronous active-low reset clears the valid bits only.
module straight_alpha_over_blend (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // dst_red, dst_green, dst_blue, dst_alpha, src_red, src_green, src_blue, src_alpha
    input  logic [saob_pkg::InDataW-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // out_red, out_green, out_blue, out_alpha
    output logic [saob_pkg::OutDataW-1:0]  m_tdata
);

    localparam int Cw = saob_pkg::ChanW;

    logic [saob_pkg::PipeDepth-1:0] vld_reg;
    logic [saob_pkg::PipeDepth-1:0] adv;

    saob_pkg::prod_stage_t prod_reg, prod_next;
    saob_pkg::div_stage_t  div_reg  [saob_pkg::DivSteps+1];
    saob_pkg::div_stage_t  div_next [saob_pkg::DivSteps+1];

    // advance chain: a stage moves when empty or when its successor moves
    always_comb begin
        adv[saob_pkg::PipeDepth-1] = !vld_reg[saob_pkg::PipeDepth-1] || m_tready;
        for (int i = saob_pkg::PipeDepth - 2; i >= 0; i--) begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign s_tready = adv[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (adv[0]) begin
                vld_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < saob_pkg::PipeDepth; i++) begin
                if (adv[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // stage 1: alpha weights and source colour products
    always_comb begin
        saob_pkg::chan_t src_a;
        saob_pkg::chan_t dst_a;
        saob_pkg::chan_t inv_a;
        src_a = s_tdata[7*Cw +: Cw];
        dst_a = s_tdata[3*Cw +: Cw];
        inv_a = ~src_a;
        prod_next.src_weight = {src_a, {Cw{1'b0}}} - {{Cw{1'b0}}, src_a};
        prod_next.dst_weight = saob_pkg::ProdW'(dst_a) * saob_pkg::ProdW'(inv_a);
        for (int c = 0; c <= saob_pkg::LaneBlue; c++) begin
            prod_next.src_prod[c] = saob_pkg::ProdW'(s_tdata[(4 + c)*Cw +: Cw])
                                  * saob_pkg::ProdW'(src_a);
            prod_next.dst_color[c] = s_tdata[c*Cw +: Cw];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            prod_reg <= prod_next;
        end
    end

    // stage 2: weighted alpha sum, the three colour numerators and the alpha
    always_comb begin
        saob_pkg::prod_t sum;
        saob_pkg::prod_t alpha_acc;
        sum = prod_reg.src_weight + prod_reg.dst_weight;
        // floor(sum / 255) for sum up to 65025: add the high byte and one, keep the high byte
        alpha_acc = sum + (sum >> Cw) + saob_pkg::ProdW'(1);
        div_next[0].zero    = (sum == '0);
        div_next[0].divisor = sum;
        div_next[0].quo     = '0;
        div_next[0].quo[saob_pkg::LaneAlpha] = alpha_acc[saob_pkg::ProdW-1:Cw];
        for (int c = 0; c <= saob_pkg::LaneBlue; c++) begin
            div_next[0].rem[c] = {prod_reg.src_prod[c], {Cw{1'b0}}}
                               - {{Cw{1'b0}}, prod_reg.src_prod[c]}
                               + saob_pkg::NumW'(prod_reg.dst_color[c])
                               * saob_pkg::NumW'(prod_reg.dst_weight);
        end
        div_next[0].rem[saob_pkg::LaneAlpha] = '0;
    end

    always_ff @(posedge aclk) begin
        if (adv[1]) begin
            div_reg[0] <= div_next[0];
        end
    end

    // stages 3..10: one restoring quotient bit per stage, MSB first
    for (genvar k = 0; k < saob_pkg::DivSteps; k++) begin : g_div
        localparam int Shift = saob_pkg::DivSteps - 1 - k;

        always_comb begin
            saob_pkg::num_t  trial;
            div_next[k+1] = div_reg[k];
            trial = saob_pkg::NumW'(div_reg[k].divisor) << Shift;
            for (int l = 0; l <= saob_pkg::LaneBlue; l++) begin
                if (div_reg[k].rem[l] >= trial) begin
                    div_next[k+1].rem[l]        = div_reg[k].rem[l] - trial;
                    div_next[k+1].quo[l][Shift] = 1'b1;
                end
            end
            // both alphas zero: a zero divisor would saturate, force black
            if (Shift == 0 && div_reg[k].zero) begin
                div_next[k+1].quo = '0;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv[k+2]) begin
                div_reg[k+1] <= div_next[k+1];
            end
        end
    end

    assign m_tvalid = vld_reg[saob_pkg::PipeDepth-1];
    assign m_tdata  = div_reg[saob_pkg::DivSteps].quo;

endmodule

// File: hw/rtl/saob_checker.sv
// Port-level checker for straight_alpha_over_blend, attached by bind.
// Depends on saob_pkg for payload widths and lane indices.
module saob_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [saob_pkg::InDataW-1:0]   s_tdata,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [saob_pkg::OutDataW-1:0]  m_tdata
);

    localparam int Cw = saob_pkg::ChanW;

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result presented right after reset");

    // a stalled result holds until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or vanished");

    // an open sink never stalls the source side
    a_no_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled although output is open");

    // zero combined alpha only when both alphas are zero, which yields black
    a_clear_black: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[saob_pkg::LaneAlpha*Cw +: Cw] == '0
        |-> m_tdata[saob_pkg::LaneAlpha*Cw-1:0] == '0)
        else $error("colour nonzero with zero combined alpha");

endmodule

bind straight_alpha_over_blend saob_checker u_saob_checker (.*);

// File: test/straight_alpha_over_blend_test.sv
// Self-checking testbench for straight_alpha_over_blend: directed pixels, then random ones,
// with random gaps on the input side and random backpressure on the output side.
// Depends on saob_pkg for channel widths, lane indices and pipeline depth.
module straight_alpha_over_blend_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RandomPixels = 1600;
    localparam int QuietLimit   = 2000;
    localparam int MaxWait      = 12;

    // red sits in the lowest byte, alpha in the highest
    typedef struct packed {
        saob_pkg::chan_t alpha;
        saob_pkg::chan_t blue;
        saob_pkg::chan_t green;
        saob_pkg::chan_t red;
    } rgba_t;

    // dst pixel in the low half of s_tdata, src pixel in the high half
    typedef struct packed {
        rgba_t src;
        rgba_t dst;
    } pixel_pair_t;

    typedef struct {
        rgba_t dst;
        rgba_t src;
        bit    known;
        rgba_t want;
    } stim_row_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [saob_pkg::InDataW-1:0]   s_tdata  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [saob_pkg::OutDataW-1:0]  m_tdata;

    rgba_t       expected_pixels[$];
    stim_row_t   directed_rows[$];
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;
    bit          send_burst     = 1'b0;

    straight_alpha_over_blend dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic rgba_t pix(int unsigned r, int unsigned g, int unsigned b,
                                  int unsigned a);
        rgba_t p;
        p.red   = saob_pkg::chan_t'(r);
        p.green = saob_pkg::chan_t'(g);
        p.blue  = saob_pkg::chan_t'(b);
        p.alpha = saob_pkg::chan_t'(a);
        return p;
    endfunction

    function automatic saob_pkg::chan_t blend_lane(saob_pkg::chan_t ca, saob_pkg::chan_t cb,
                                                   saob_pkg::chan_t aa, saob_pkg::chan_t ab,
                                                   int unsigned weight_sum);
        int unsigned numer;
        int unsigned quot;
        numer = ca * aa * 255 + cb * ab * (255 - aa);
        quot  = numer / weight_sum;
        return (quot > 255) ? saob_pkg::chan_t'(255) : saob_pkg::chan_t'(quot);
    endfunction

    // straight-alpha over, exact integer form, truncating divisions
    function automatic rgba_t blend_over(pixel_pair_t px);
        rgba_t       res;
        int unsigned weight_sum;
        weight_sum = px.src.alpha * 255 + px.dst.alpha * (255 - px.src.alpha);
        if (weight_sum == 0) begin
            return '0;
        end
        res.red   = blend_lane(px.src.red, px.dst.red, px.src.alpha, px.dst.alpha, weight_sum);
        res.green = blend_lane(px.src.green, px.dst.green, px.src.alpha, px.dst.alpha,
                               weight_sum);
        res.blue  = blend_lane(px.src.blue, px.dst.blue, px.src.alpha, px.dst.alpha, weight_sum);
        res.alpha = saob_pkg::chan_t'(weight_sum / 255);
        return res;
    endfunction

    function automatic saob_pkg::chan_t rand_alpha();
        unique case ($urandom_range(0, 7))
            0: return saob_pkg::chan_t'(0);
            1: return saob_pkg::chan_t'(255);
            2: return saob_pkg::chan_t'($urandom_range(1, 3));
            3: return saob_pkg::chan_t'($urandom_range(252, 254));
            default: return saob_pkg::chan_t'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_pixel(input rgba_t dst, input rgba_t src, input bit known,
                              input rgba_t want);
        pixel_pair_t px;
        int unsigned gap;
        px.dst = dst;
        px.src = src;
        gap = send_burst ? 0 : $urandom_range(0, MaxWait);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        expected_pixels.push_back(known ? want : blend_over(px));
        @(negedge aclk);
    endtask

    task automatic check_pixel(input rgba_t got);
        rgba_t want;
        string lane_name[saob_pkg::LaneCount];
        lane_name[saob_pkg::LaneRed]   = "out_red";
        lane_name[saob_pkg::LaneGreen] = "out_green";
        lane_name[saob_pkg::LaneBlue]  = "out_blue";
        lane_name[saob_pkg::LaneAlpha] = "out_alpha";
        if (expected_pixels.size() == 0) begin
            $error("unexpected result %h with no request pending", got);
            mismatch_count++;
            return;
        end
        want = expected_pixels.pop_front();
        for (int lane = 0; lane < saob_pkg::LaneCount; lane++) begin
            if (got[lane*saob_pkg::ChanW +: saob_pkg::ChanW]
                    !== want[lane*saob_pkg::ChanW +: saob_pkg::ChanW]) begin
                $error("%s: expected %0d, actual %0d", lane_name[lane],
                       want[lane*saob_pkg::ChanW +: saob_pkg::ChanW],
                       got[lane*saob_pkg::ChanW +: saob_pkg::ChanW]);
                mismatch_count++;
            end
        end
    endtask

    // result side: random stall before each result, with stretches of none
    initial begin
        int unsigned stall;
        bit          take_burst;
        int unsigned taken;
        take_burst = 1'b0;
        taken = 0;
        wait (aresetn);
        forever begin
            if (taken % 64 == 0) begin
                take_burst = ($urandom_range(0, 3) == 0);
            end
            stall = take_burst ? 0 : $urandom_range(0, MaxWait);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            check_pixel(rgba_t'(m_tdata));
            taken++;
            @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QuietLimit) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        rgba_t dst;
        rgba_t src;
        // both alphas zero: everything clears; then opaque white over opaque white
        directed_rows.push_back('{pix(0, 0, 0, 0), pix(0, 0, 0, 0), 1'b1, pix(0, 0, 0, 0)});
        directed_rows.push_back('{pix(255, 255, 255, 0), pix(255, 255, 255, 0), 1'b1,
                                  pix(0, 0, 0, 0)});
        directed_rows.push_back('{pix(255, 255, 255, 255), pix(255, 255, 255, 255), 1'b1,
                                  pix(255, 255, 255, 255)});
        // opaque source replaces the background
        directed_rows.push_back('{pix(200, 100, 50, 77), pix(12, 34, 56, 255), 1'b1,
                                  pix(12, 34, 56, 255)});
        directed_rows.push_back('{pix(255, 255, 255, 255), pix(0, 0, 0, 255), 1'b1,
                                  pix(0, 0, 0, 255)});
        // transparent source leaves the background
        directed_rows.push_back('{pix(9, 8, 7, 255), pix(255, 255, 255, 0), 1'b1,
                                  pix(9, 8, 7, 255)});
        directed_rows.push_back('{pix(90, 60, 30, 128), pix(1, 2, 3, 0), 1'b1,
                                  pix(90, 60, 30, 128)});
        // transparent background passes the source; the rows after it are checked against blend_over
        directed_rows.push_back('{pix(44, 55, 66, 0), pix(255, 0, 170, 1), 1'b1,
                                  pix(255, 0, 170, 1)});
        directed_rows.push_back('{pix(255, 255, 255, 0), pix(85, 170, 255, 254), 1'b1,
                                  pix(85, 170, 255, 254)});
        directed_rows.push_back('{pix(255, 255, 255, 255), pix(0, 0, 0, 1), 1'b0, '0});
        directed_rows.push_back('{pix(0, 0, 0, 1), pix(255, 255, 255, 254), 1'b0, '0});
        directed_rows.push_back('{pix(10, 200, 30, 128), pix(250, 20, 130, 128), 1'b0, '0});
        directed_rows.push_back('{pix(255, 0, 255, 1), pix(0, 255, 0, 1), 1'b0, '0});
        directed_rows.push_back('{pix(0, 255, 0, 255), pix(255, 0, 255, 127), 1'b0, '0});
        directed_rows.push_back('{pix(255, 0, 255, 1), pix(0, 255, 0, 128), 1'b0, '0});
        directed_rows.push_back('{pix(170, 85, 170, 85), pix(85, 170, 85, 170), 1'b0, '0});
        directed_rows.push_back('{pix(255, 255, 255, 254), pix(255, 255, 255, 254), 1'b0, '0});

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_pixel(directed_rows[i].dst, directed_rows[i].src, directed_rows[i].known,
                       directed_rows[i].want);
        end

        for (int n = 0; n < RandomPixels; n++) begin
            if (n % 64 == 0) begin
                send_burst = ($urandom_range(0, 3) == 0);
            end
            dst = pix($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                      rand_alpha());
            src = pix($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                      rand_alpha());
            send_pixel(dst, src, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (expected_pixels.size() != 0) @(posedge aclk);
        // catch any stray result behind the last one
        repeat (saob_pkg::PipeDepth + 4) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: straight_alpha_over_blend.f
hw/rtl/saob_pkg.sv
hw/rtl/straight_alpha_over_blend.sv
hw/rtl/saob_checker.sv
test/straight_alpha_over_blend_test.sv
